FILE: hw/rtl/fsi_pkg.sv
package fsi_pkg;

	typedef struct packed {
		logic [7:0]  fmt_char;
		logic [63:0] arg_value;
	} fsi_fmt_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        char_valid;
		logic        last_of_run;
		logic        format_done;
		logic [31:0] emitted_count;
	} fsi_res_t;

	typedef enum logic [1:0] {
		PS_PLAIN,
		PS_PERCENT,
		PS_ESCAPE,
		PS_LONG
	} parse_state_t;

	typedef enum logic [1:0] {
		DM_NONE,
		DM_DEC,
		DM_HEX
	} dig_mode_t;

	typedef enum logic [1:0] {
		DG_IDLE,
		DG_CONV,
		DG_SKIP,
		DG_EMIT
	} dig_phase_t;

	typedef struct packed {
		logic start;
		logic is_hex;
		logic is_long;
	} dig_cmd_t;

	typedef struct packed {
		logic       ready;
		logic       last;
		logic [3:0] digit;
	} dig_stat_t;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOW_C   = 8'h63;
	localparam logic [7:0] CH_LOW_D   = 8'h64;
	localparam logic [7:0] CH_LOW_L   = 8'h6c;
	localparam logic [7:0] CH_LOW_N   = 8'h6e;
	localparam logic [7:0] CH_LOW_P   = 8'h70;
	localparam logic [7:0] CH_LOW_R   = 8'h72;
	localparam logic [7:0] CH_LOW_T   = 8'h74;
	localparam logic [7:0] CH_LOW_X   = 8'h78;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] HEX_ALPHA  = 8'h57;
	localparam logic [3:0] NIB_TEN    = 4'ha;

	function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
		logic [7:0] r;
		if (nib >= NIB_TEN) begin
			r = {4'h0, nib} + HEX_ALPHA;
		end else begin
			r = {4'h0, nib} + CH_ZERO;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/fsi_digit_unit.sv
module fsi_digit_unit import fsi_pkg::*; #(
	parameter int LW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dig_cmd_t      cmd,
	input  logic [LW-1:0] value,
	input  logic          pop,
	output dig_stat_t     stat
);

	localparam int ND  = (LW * 30103) / 100000 + 1;
	localparam int DW  = 4 * ND;
	localparam int HN  = (LW + 3) / 4;
	localparam int HBW = 4 * HN;
	localparam int CW  = $clog2(LW + 1);
	localparam int RW  = $clog2(ND + 1);

	dig_phase_t    phase_q, phase_d;
	logic [DW-1:0] dig_q;
	logic [DW-1:0] adj;
	logic [LW-1:0] bin_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [3:0]    top_nib;
	logic          skip_zero;

	assign top_nib   = dig_q[DW-1 -: 4];
	assign skip_zero = (top_nib == 4'h0) && (rem_q > RW'(1));

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
				: dig_q[4*i +: 4];
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			DG_IDLE: begin
				if (cmd.start) begin
					phase_d = cmd.is_hex ? DG_SKIP : DG_CONV;
				end
			end
			DG_CONV: begin
				if (cnt_q == CW'(1)) begin
					phase_d = DG_SKIP;
				end
			end
			DG_SKIP: begin
				if (!skip_zero) begin
					phase_d = DG_EMIT;
				end
			end
			DG_EMIT: begin
				if (pop && rem_q == RW'(1)) begin
					phase_d = DG_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		stat.ready = (phase_q == DG_EMIT);
		stat.last  = (rem_q == RW'(1));
		stat.digit = top_nib;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DG_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			DG_IDLE: begin
				if (cmd.start) begin
					if (cmd.is_hex) begin
						dig_q <= cmd.is_long ? DW'(value) << (DW - HBW)
							: DW'(value[31:0]) << (DW - 32);
						rem_q <= cmd.is_long ? RW'(HN) : RW'(8);
					end else begin
						dig_q <= '0;
						bin_q <= cmd.is_long ? value : value << (LW - 32);
						cnt_q <= cmd.is_long ? CW'(LW) : CW'(32);
						rem_q <= RW'(ND);
					end
				end
			end
			DG_CONV: begin
				dig_q <= {adj[DW-2:0], bin_q[LW-1]};
				bin_q <= bin_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
			DG_SKIP: begin
				if (skip_zero) begin
					dig_q <= dig_q << 4;
					rem_q <= rem_q - RW'(1);
				end
			end
			DG_EMIT: begin
				if (pop) begin
					dig_q <= dig_q << 4;
					rem_q <= rem_q - RW'(1);
				end
			end
		endcase
	end

endmodule

FILE: hw/rtl/format_string_interpreter.sv
// Format string interpreter.
// Input channel fmt_valid / fmt_stall / fmt_item takes one format byte per
// transfer, with the argument word used only when the byte ends a conversion.
// Output channel res_valid / res_stall / res_item gives one character per
// transfer; the last transfer of a byte carries last_of_run, and a string end
// carries format_done. A NUL in plain text gives one transfer with
// char_valid low and the running count.
// One byte is worked at a time; fmt_stall is high from the accepting edge
// until its last character sits in the output register. Bytes that only
// open an escape or conversion give no transfer and leave fmt_stall low.
// A copied byte waits in the prefix register until the output slot is free,
// then moves to the output register and frees the input at the same edge.
// Prefix characters go one per cycle while the output is not stalled.
// Decimal conversions run a bit-serial binary to BCD loop over 32 or
// LONG_WIDTH bits, skip leading zero digits one per cycle, then give one
// digit per cycle while the output is not stalled. Hex skips leading zero
// nibbles one per cycle and gives one digit per cycle likewise.
// Reset clears the parser to plain text and the count to zero and empties
// the output register. While res_stall is high and res_valid is set, the
// output register holds and the character sequence pauses; nothing is dropped.
module format_string_interpreter import fsi_pkg::*; #(
	parameter int LONG_WIDTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fmt_valid,
	output logic     fmt_stall,
	input  fsi_fmt_t fmt_item,
	output logic     res_valid,
	input  logic     res_stall,
	output fsi_res_t res_item
);

	localparam int LW = LONG_WIDTH;

	parse_state_t  parse_q, parse_d;
	logic          busy_q;
	logic [23:0]   pre_q;
	logic [1:0]    pre_n_q;
	dig_mode_t     dmode_q;
	logic          done_q;
	logic          bare_q;
	logic [31:0]   total_q;
	fsi_res_t      res_q;
	logic          res_valid_q;

	logic          fmt_acc;
	logic [7:0]    c;
	logic          lng;
	logic          neg;
	logic [LW-1:0] dec_src;
	logic [LW-1:0] mag;
	logic [LW-1:0] unit_val;
	logic [23:0]   d_pre;
	logic [1:0]    d_pre_n;
	dig_mode_t     d_mode;
	logic          d_done;
	logic          d_bare;
	logic          d_has;

	dig_cmd_t      dcmd;
	dig_stat_t     dstat;

	logic          slot_free;
	logic          take_pre;
	logic          take_dig;
	logic          take_bare;
	logic          emit;
	logic          last;
	logic [31:0]   cnt_inc;

	assign fmt_acc   = fmt_valid && !busy_q;
	assign fmt_stall = busy_q;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign c       = fmt_item.fmt_char;
	assign lng     = (parse_q == PS_LONG);
	assign neg     = lng ? fmt_item.arg_value[LW-1] : fmt_item.arg_value[31];
	assign dec_src = lng ? fmt_item.arg_value[LW-1:0] : LW'(fmt_item.arg_value[31:0]);

	always_comb begin
		mag = neg ? (~dec_src + LW'(1)) : dec_src;
		if (!lng) begin
			mag = mag & LW'(32'hffff_ffff);
		end
		unit_val = (d_mode == DM_HEX) ? dec_src : mag;
	end

	always_comb begin
		parse_d = PS_PLAIN;
		unique case (parse_q)
			PS_PLAIN: begin
				if (c == CH_PERCENT) begin
					parse_d = PS_PERCENT;
				end else if (c == CH_BSLASH) begin
					parse_d = PS_ESCAPE;
				end
			end
			PS_PERCENT: begin
				if (c == CH_LOW_L) begin
					parse_d = PS_LONG;
				end
			end
			PS_ESCAPE: parse_d = PS_PLAIN;
			PS_LONG:   parse_d = PS_PLAIN;
		endcase
	end

	always_comb begin
		d_pre   = '0;
		d_pre_n = 2'd0;
		d_mode  = DM_NONE;
		d_done  = 1'b0;
		d_bare  = 1'b0;
		unique case (parse_q)
			PS_PLAIN: begin
				if (c == CH_NUL) begin
					d_done = 1'b1;
					d_bare = 1'b1;
				end else if (c != CH_PERCENT && c != CH_BSLASH) begin
					d_pre   = {c, 16'h0};
					d_pre_n = 2'd1;
				end
			end
			PS_PERCENT: begin
				unique case (c)
					CH_NUL: begin
						d_pre   = {CH_PERCENT, 16'h0};
						d_pre_n = 2'd1;
						d_done  = 1'b1;
					end
					CH_LOW_C: begin
						d_pre   = {fmt_item.arg_value[7:0], 16'h0};
						d_pre_n = 2'd1;
					end
					CH_LOW_D: begin
						d_mode = DM_DEC;
						if (neg) begin
							d_pre   = {CH_MINUS, 16'h0};
							d_pre_n = 2'd1;
						end
					end
					CH_LOW_L: d_mode = DM_NONE;
					CH_LOW_P: begin
						d_pre   = {CH_ZERO, CH_LOW_X, 8'h0};
						d_pre_n = 2'd2;
						d_mode  = DM_HEX;
					end
					CH_LOW_X: d_mode = DM_HEX;
					default: begin
						d_pre   = {CH_PERCENT, c, 8'h0};
						d_pre_n = 2'd2;
					end
				endcase
			end
			PS_ESCAPE: begin
				d_pre_n = 2'd1;
				unique case (c)
					CH_NUL: begin
						d_pre  = {CH_BSLASH, 16'h0};
						d_done = 1'b1;
					end
					CH_LOW_N: d_pre = {CH_LF, 16'h0};
					CH_LOW_R: d_pre = {CH_CR, 16'h0};
					CH_LOW_T: d_pre = {CH_TAB, 16'h0};
					default:  d_pre = {c, 16'h0};
				endcase
			end
			PS_LONG: begin
				unique case (c)
					CH_LOW_D: begin
						d_mode = DM_DEC;
						if (neg) begin
							d_pre   = {CH_MINUS, 16'h0};
							d_pre_n = 2'd1;
						end
					end
					CH_LOW_X: d_mode = DM_HEX;
					CH_NUL: begin
						d_pre   = {CH_PERCENT, CH_LOW_L, 8'h0};
						d_pre_n = 2'd2;
						d_done  = 1'b1;
					end
					default: begin
						d_pre   = {CH_PERCENT, CH_LOW_L, c};
						d_pre_n = 2'd3;
					end
				endcase
			end
		endcase
		d_has = d_bare || (d_pre_n != 2'd0) || (d_mode != DM_NONE);
	end

	always_comb begin
		dcmd.start   = fmt_acc && (d_mode != DM_NONE);
		dcmd.is_hex  = (d_mode == DM_HEX);
		dcmd.is_long = lng;
	end

	fsi_digit_unit #(
		.LW(LW)
	) u_digit (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (dcmd),
		.value (unit_val),
		.pop   (take_dig),
		.stat  (dstat)
	);

	always_comb begin
		slot_free = !res_valid_q || !res_stall;
		take_bare = busy_q && bare_q && slot_free;
		take_pre  = busy_q && !bare_q && (pre_n_q != 2'd0) && slot_free;
		take_dig  = busy_q && (pre_n_q == 2'd0) && (dmode_q != DM_NONE)
			&& dstat.ready && slot_free;
		emit      = take_bare || take_pre || take_dig;
		last      = take_bare || (take_pre && pre_n_q == 2'd1 && dmode_q == DM_NONE)
			|| (take_dig && dstat.last);
		cnt_inc   = (total_q == 32'hffff_ffff) ? total_q : total_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q     <= PS_PLAIN;
			busy_q      <= 1'b0;
			pre_n_q     <= 2'd0;
			dmode_q     <= DM_NONE;
			done_q      <= 1'b0;
			bare_q      <= 1'b0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fmt_acc) begin
				parse_q <= d_done ? PS_PLAIN : parse_d;
				busy_q  <= d_has;
				pre_n_q <= d_pre_n;
				dmode_q <= d_mode;
				done_q  <= d_done;
				bare_q  <= d_bare;
			end else begin
				if (take_pre) begin
					pre_n_q <= pre_n_q - 2'd1;
				end
				if (emit && last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				if (last && done_q) begin
					total_q <= '0;
				end else if (!take_bare) begin
					total_q <= cnt_inc;
				end
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fmt_acc) begin
			pre_q <= d_pre;
		end else if (take_pre) begin
			pre_q <= pre_q << 8;
		end
		if (emit) begin
			res_q.out_char      <= take_bare ? CH_NUL
				: (take_pre ? pre_q[23:16] : nib_to_ascii(dstat.digit));
			res_q.char_valid    <= !take_bare;
			res_q.last_of_run   <= last;
			res_q.format_done   <= done_q;
			res_q.emitted_count <= take_bare ? total_q : cnt_inc;
		end
	end

endmodule
